[hw/rtl/ncint_pkg.sv]
package ncint_pkg;

  localparam int SAMPLE_W = 32;
  localparam int MAX_DIV  = 65536;
  localparam int IDX_W    = $clog2(MAX_DIV + 1);
  localparam int ACC_W    = 64;
  localparam int STEP_W   = 32;
  localparam int MODE_W   = 2;
  localparam int RES_W    = 48;
  localparam int STAT_W   = 2;
  localparam int WGT_W    = 3;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);
  localparam int CFG_IDX_W = 1;

  localparam logic [MODE_W-1:0] MODE_TRAP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_S13  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_S38  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NODIV = 2'd1;
  localparam logic [STAT_W-1:0] ST_SAT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RULE_MODE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_WIDTH = 1'b1;

  localparam logic [WGT_W-1:0] W_ONE   = 3'd1;
  localparam logic [WGT_W-1:0] W_TWO   = 3'd2;
  localparam logic [WGT_W-1:0] W_THREE = 3'd3;
  localparam logic [WGT_W-1:0] W_FOUR  = 3'd4;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    K_ACC   = 2'd0,
    K_DROP  = 2'd1,
    K_EMPTY = 2'd2,
    K_LAST  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic [WGT_W-1:0]            weight;
    logic [MODE_W-1:0]           mode;
    logic signed [SAMPLE_W-1:0]  value;
  } entry_t;

endpackage

[hw/rtl/ncint_front.sv]
module ncint_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ncint_pkg::SAMPLE_W-1:0]  in_tdata,   // sample_value
  input  logic                            in_tlast,
  input  logic [ncint_pkg::MODE_W-1:0]    rule_mode,
  input  logic                            q_full,
  output logic                            q_push,
  output ncint_pkg::entry_t               q_entry
);
  import ncint_pkg::*;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [1:0]       mod3_r, mod3_nxt;
  logic [WGT_W-1:0] inner_w;
  logic             accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && !q_full;
  assign q_push    = accept;

  always_comb begin
    case (rule_mode)
      MODE_S13: inner_w = idx_r[0] ? W_FOUR : W_TWO;
      MODE_S38: inner_w = (mod3_r == 2'd0) ? W_TWO : W_THREE;
      default:  inner_w = W_TWO;
    endcase
  end

  always_comb begin
    q_entry.value  = signed'(in_tdata);
    q_entry.mode   = rule_mode;
    q_entry.weight = W_ONE;
    q_entry.kind   = K_ACC;
    idx_nxt        = idx_r;
    mod3_nxt       = mod3_r;
    if (in_tlast) begin
      q_entry.kind = (idx_r == '0) ? K_EMPTY : K_LAST;
      idx_nxt      = '0;
      mod3_nxt     = 2'd0;
    end else if (idx_r == '0) begin
      idx_nxt  = IDX_W'(1);
      mod3_nxt = 2'd1;
    end else if (idx_r < IDX_W'(MAX_DIV)) begin
      q_entry.weight = inner_w;
      idx_nxt        = idx_r + IDX_W'(1);
      mod3_nxt       = (mod3_r == 2'd2) ? 2'd0 : mod3_r + 2'd1;
    end else begin
      q_entry.kind = K_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      mod3_r <= 2'd0;
    end else if (accept) begin
      idx_r  <= idx_nxt;
      mod3_r <= mod3_nxt;
    end
  end

endmodule

[hw/rtl/ncint_queue.sv]
module ncint_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ncint_pkg::entry_t  push_entry,
  output logic               full,
  input  logic               pop,
  output ncint_pkg::entry_t  head_entry,
  output logic               empty
);
  import ncint_pkg::*;

  entry_t            slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  assign full       = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty      = (count_r == '0);
  assign do_push    = push && !full;
  assign do_pop     = pop && !empty;
  assign head_entry = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

[hw/rtl/ncint_back.sv]
module ncint_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_empty,
  input  ncint_pkg::entry_t              q_entry,
  output logic                           q_pop,
  input  logic [ncint_pkg::STEP_W-1:0]   step_width,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ncint_pkg::RES_W-1:0]    out_tdata,   // integral_value
  output logic [ncint_pkg::STAT_W-1:0]   out_tuser    // status_code
);
  import ncint_pkg::*;

  localparam int X_W      = 98;
  localparam int T_W      = 74;
  localparam int D_W      = 50;
  localparam int WV_W     = SAMPLE_W + 3;
  localparam int DCNT_W   = 2;
  localparam int PP_W     = 25;
  localparam logic [D_W-1:0] RECIP3 = 50'h1555555555556;

  typedef enum logic [9:0] {
    B_RUN    = 10'b0000000001,
    B_ABS    = 10'b0000000010,
    B_MLO    = 10'b0000000100,
    B_MHI    = 10'b0000001000,
    B_SUM    = 10'b0000010000,
    B_TRIPLE = 10'b0000100000,
    B_ROUND  = 10'b0001000000,
    B_CHECK  = 10'b0010000000,
    B_DIV    = 10'b0100000000,
    B_FIN    = 10'b1000000000
  } bstate_t;

  bstate_t             state_r, state_nxt;
  logic [ACC_W-1:0]    sum_r, sum_nxt;
  logic                clip_r, clip_nxt;
  logic [MODE_W-1:0]   mode_r, mode_nxt;
  logic                neg_r, neg_nxt;
  logic [ACC_W-1:0]    mag_r, mag_nxt;
  logic [63:0]         lo_r, lo_nxt, hi_r, hi_nxt;
  logic [X_W-1:0]      x_r, x_nxt;
  logic [T_W-1:0]      t_r, t_nxt;
  logic [D_W-1:0]      div_r, div_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                sat_r, sat_nxt;
  logic                out_valid_r;
  logic [RES_W-1:0]    out_data_r, out_data_nxt;
  logic [STAT_W-1:0]   out_user_r, out_user_nxt;
  logic                out_load, out_free;

  logic signed [WV_W-1:0] wv, v_ext;
  logic [ACC_W:0]      s_ext;
  logic                acc_ovf;
  logic [ACC_W-1:0]    acc_val;
  logic [31:0]         mul_a;
  logic [63:0]         prod;
  logic [X_W-1:0]      rnd, rounded, shifted;
  logic [D_W-1:0]      lim, lim_p1, lim3;
  logic                big;
  logic [PP_W-1:0]     pp_a, pp_b;
  logic [2*PP_W-1:0]   pp;
  logic [X_W-1:0]      pp_sh, acc_pp;
  logic [RES_W-1:0]    qv;

  assign v_ext = WV_W'(q_entry.value);

  always_comb begin
    case (q_entry.weight)
      W_TWO:   wv = v_ext <<< 1;
      W_THREE: wv = v_ext + (v_ext <<< 1);
      W_FOUR:  wv = v_ext <<< 2;
      default: wv = v_ext;
    endcase
  end

  assign s_ext   = {sum_r[ACC_W-1], sum_r} + (ACC_W+1)'(wv);
  assign acc_ovf = s_ext[ACC_W] != s_ext[ACC_W-1];
  assign acc_val = acc_ovf ? (s_ext[ACC_W] ? ACC_MIN : ACC_MAX) : s_ext[ACC_W-1:0];

  assign mul_a = (state_r == B_MLO) ? mag_r[31:0] : mag_r[63:32];
  assign prod  = mul_a * step_width;

  always_comb begin
    case (mode_r)
      MODE_S38: begin
        rnd     = X_W'(1) << 26;
        rounded = x_r + rnd;
        shifted = rounded >> 27;
      end
      MODE_S13: begin
        rnd     = X_W'(3) << 23;
        rounded = x_r + rnd;
        shifted = rounded >> 24;
      end
      default: begin
        rnd     = X_W'(1) << 24;
        rounded = x_r + rnd;
        shifted = rounded >> 25;
      end
    endcase
  end

  assign lim    = neg_r ? (D_W'(1) << 47) : ((D_W'(1) << 47) - D_W'(1));
  assign lim_p1 = lim + D_W'(1);
  assign lim3   = lim_p1 + (lim_p1 << 1);
  assign big    = (mode_r == MODE_S13) ? (t_r >= T_W'(lim3)) : (t_r > T_W'(lim));

  // divide by 3: multiply by the reciprocal, one partial product per cycle
  assign pp_a = dcnt_r[1] ? div_r[PP_W-1:0] : div_r[D_W-1:PP_W];
  assign pp_b = dcnt_r[0] ? RECIP3[PP_W-1:0] : RECIP3[D_W-1:PP_W];
  assign pp   = pp_a * pp_b;

  always_comb begin
    case (dcnt_r)
      DCNT_W'(3): pp_sh = X_W'(pp);
      DCNT_W'(0): pp_sh = X_W'(pp) << (2*PP_W);
      default:    pp_sh = X_W'(pp) << PP_W;
    endcase
  end

  assign acc_pp = x_r + pp_sh;

  assign qv       = div_r[RES_W-1:0];
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    sum_nxt      = sum_r;
    clip_nxt     = clip_r;
    mode_nxt     = mode_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    x_nxt        = x_r;
    t_nxt        = t_r;
    div_nxt      = div_r;
    dcnt_nxt     = dcnt_r;
    sat_nxt      = sat_r;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    out_load     = 1'b0;
    q_pop        = 1'b0;
    case (state_r)
      B_RUN: begin
        if (!q_empty) begin
          case (q_entry.kind)
            K_ACC: begin
              q_pop    = 1'b1;
              sum_nxt  = acc_val;
              clip_nxt = clip_r | acc_ovf;
            end
            K_DROP: begin
              q_pop    = 1'b1;
              clip_nxt = 1'b1;
            end
            K_EMPTY: begin
              if (out_free) begin
                q_pop        = 1'b1;
                out_load     = 1'b1;
                out_data_nxt = '0;
                out_user_nxt = ST_NODIV;
                sum_nxt      = '0;
                clip_nxt     = 1'b0;
              end
            end
            default: begin
              q_pop     = 1'b1;
              sum_nxt   = acc_val;
              clip_nxt  = clip_r | acc_ovf;
              mode_nxt  = q_entry.mode;
              state_nxt = B_ABS;
            end
          endcase
        end
      end
      B_ABS: begin
        neg_nxt   = sum_r[ACC_W-1];
        mag_nxt   = sum_r[ACC_W-1] ? (~sum_r + ACC_W'(1)) : sum_r;
        state_nxt = B_MLO;
      end
      B_MLO: begin
        lo_nxt    = prod;
        state_nxt = B_MHI;
      end
      B_MHI: begin
        hi_nxt    = prod;
        state_nxt = B_SUM;
      end
      B_SUM: begin
        x_nxt     = X_W'(lo_r) + (X_W'(hi_r) << 32);
        state_nxt = B_TRIPLE;
      end
      B_TRIPLE: begin
        if (mode_r == MODE_S38) x_nxt = x_r + (x_r << 1);
        state_nxt = B_ROUND;
      end
      B_ROUND: begin
        t_nxt     = shifted[T_W-1:0];
        state_nxt = B_CHECK;
      end
      B_CHECK: begin
        sat_nxt = clip_r | big;
        if (big) begin
          div_nxt   = lim;
          state_nxt = B_FIN;
        end else begin
          div_nxt = t_r[D_W-1:0];
          if (mode_r == MODE_S13) begin
            x_nxt     = '0;
            dcnt_nxt  = DCNT_W'(3);
            state_nxt = B_DIV;
          end else begin
            state_nxt = B_FIN;
          end
        end
      end
      B_DIV: begin
        x_nxt    = acc_pp;
        dcnt_nxt = dcnt_r - DCNT_W'(1);
        if (dcnt_r == '0) begin
          div_nxt   = D_W'(acc_pp[X_W-1:2*PP_W]);
          state_nxt = B_FIN;
        end
      end
      B_FIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_data_nxt = neg_r ? (~qv + RES_W'(1)) : qv;
          out_user_nxt = sat_r ? ST_SAT : ST_OK;
          sum_nxt      = '0;
          clip_nxt     = 1'b0;
          state_nxt    = B_RUN;
        end
      end
      default: state_nxt = B_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    x_r        <= x_nxt;
    t_r        <= t_nxt;
    div_r      <= div_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    neg_r      <= neg_nxt;
    sat_r      <= sat_nxt;
    mode_r     <= mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_RUN;
      sum_r       <= '0;
      clip_r      <= 1'b0;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      clip_r  <= clip_nxt;
      dcnt_r  <= dcnt_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == B_RUN)
    else $error("queue popped outside run state");

  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV && dcnt_r != '0) |=> state_r == B_DIV)
    else $error("divider left early");

  a_clear_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (sum_r == '0 && !clip_r))
    else $error("accumulator not cleared after result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_tready))
    else $error("result word overwritten");

endmodule

[hw/rtl/newton_cotes_integrator_unit.sv]
// A sample word is accumulated at the edge after its acceptance when the queue
// is empty and the back end is in its run state; a last sample sends the sum
// through its result states, plus a divide by 3 for Simpson 1/3, to the output.
// Throughput: one sample per cycle while the queue is not full; each last
// sample keeps the back end busy; the 4-word queue takes up that stall first.
// Reset: synchronous, active low; clears the run state, rule_mode 0, step 1.0.
module newton_cotes_integrator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ncint_pkg::SAMPLE_W-1:0]    in_tdata,   // sample_value
  input  logic                              in_tlast,   // last_sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ncint_pkg::RES_W-1:0]       out_tdata,  // integral_value
  output logic [ncint_pkg::STAT_W-1:0]      out_tuser,  // status_code
  input  logic                              cfg_wr_en,
  input  logic [ncint_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ncint_pkg::STEP_W-1:0]      cfg_wdata
);
  import ncint_pkg::*;

  logic [MODE_W-1:0] rule_mode_r;
  logic [STEP_W-1:0] step_width_r;
  logic              q_full, q_empty, q_push, q_pop;
  entry_t            push_entry, head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_mode_r  <= MODE_TRAP;
      step_width_r <= STEP_W'(32'd16777216);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_RULE_MODE:  rule_mode_r  <= cfg_wdata[MODE_W-1:0];
        CFG_STEP_WIDTH: step_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ncint_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .rule_mode (rule_mode_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  ncint_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_entry (head_entry),
    .empty      (q_empty)
  );

  ncint_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (head_entry),
    .q_pop      (q_pop),
    .step_width (step_width_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
